/* hdl/ebvd_pkg.sv */
package ebvd_pkg;

  localparam int unsigned ValueWidth = 56;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned TailWidth  = 3;

  localparam logic [ValueWidth-1:0] MaxSizeReset = ValueWidth'(1000);

  localparam logic [7:0] HeadMarker = 8'h80;
  localparam logic [2:0] IdMaxTails = 3'd3;

  localparam logic ModeId   = 1'b0;
  localparam logic ModeSize = 1'b1;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrZeroHead = 2'd1;
  localparam logic [1:0] ErrIdLong   = 2'd2;
  localparam logic [1:0] ErrSizeMax  = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       mode;
  } ebvd_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] byte_count;
    logic                  kind;
    logic [1:0]            error;
  } ebvd_result_t;

  function automatic logic [2:0] lead_zeros(input logic [7:0] b);
    logic [2:0] lz;
    lz = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        lz = 3'(7 - i);
      end
    end
    return lz;
  endfunction

endpackage

/* hdl/ebvd_in_stage.sv */
module ebvd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                mode_i,
  input  logic                advance_i,
  output ebvd_pkg::ebvd_item_t item_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       mode_q;
  logic       load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= data_byte_i;
      mode_q <= mode_i;
    end
  end

  assign item_o.valid     = valid_q;
  assign item_o.data_byte = byte_q;
  assign item_o.mode      = mode_q;

endmodule

/* hdl/ebvd_decode.sv */
module ebvd_decode (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ebvd_pkg::ValueWidth-1:0]     cfg_wdata_i,
  input  ebvd_pkg::ebvd_item_t                item_i,
  input  logic                                res_ready_i,
  output logic                                advance_o,
  output logic                                res_valid_o,
  output ebvd_pkg::ebvd_result_t              res_o
);

  logic [ebvd_pkg::ValueWidth-1:0] max_size_q;
  logic                            busy_q, busy_d;
  logic [ebvd_pkg::TailWidth-1:0]  tails_q, tails_d;
  logic [ebvd_pkg::CountWidth-1:0] total_q, total_d;
  logic [ebvd_pkg::ValueWidth-1:0] acc_q, acc_d;
  logic                            mode_q, mode_d;

  logic [ebvd_pkg::ValueWidth-1:0] acc_n;
  logic [ebvd_pkg::CountWidth-1:0] total_n;
  logic [ebvd_pkg::TailWidth-1:0]  tails_n;
  logic                            kind_n;
  logic                            fin;
  logic                            emit;
  logic                            over;
  logic [2:0]                      lz;
  logic [7:0]                      b;

  assign b  = item_i.data_byte;
  assign lz = ebvd_pkg::lead_zeros(b);

  always_comb begin
    busy_d  = busy_q;
    tails_d = tails_q;
    total_d = total_q;
    acc_d   = acc_q;
    mode_d  = mode_q;
    acc_n   = acc_q;
    total_n = total_q;
    tails_n = tails_q;
    kind_n  = mode_q;
    fin     = 1'b0;
    emit    = 1'b0;
    res_o.value      = '0;
    res_o.byte_count = ebvd_pkg::CountWidth'(1);
    res_o.kind       = item_i.mode;
    res_o.error      = ebvd_pkg::ErrNone;

    if (busy_q) begin
      acc_n   = {acc_q[ebvd_pkg::ValueWidth-9:0], b};
      total_n = total_q + ebvd_pkg::CountWidth'(1);
      tails_n = tails_q - ebvd_pkg::TailWidth'(1);
      fin     = (tails_n == '0);
      busy_d  = 1'b1;
    end else begin
      mode_d  = item_i.mode;
      kind_n  = item_i.mode;
      total_n = ebvd_pkg::CountWidth'(1);
      tails_n = lz;
      if (item_i.mode == ebvd_pkg::ModeSize) begin
        acc_n = ebvd_pkg::ValueWidth'(b & ~(ebvd_pkg::HeadMarker >> lz));
      end else begin
        acc_n = ebvd_pkg::ValueWidth'(b);
      end
      fin = (lz == '0);
    end

    over = (kind_n == ebvd_pkg::ModeSize) && (acc_n > max_size_q);

    if (!busy_q && b == 8'h00) begin
      emit        = 1'b1;
      res_o.error = ebvd_pkg::ErrZeroHead;
    end else if (!busy_q && item_i.mode == ebvd_pkg::ModeId && lz > ebvd_pkg::IdMaxTails) begin
      emit        = 1'b1;
      res_o.value = ebvd_pkg::ValueWidth'(b);
      res_o.kind  = ebvd_pkg::ModeId;
      res_o.error = ebvd_pkg::ErrIdLong;
    end else if (fin) begin
      emit             = 1'b1;
      res_o.value      = acc_n;
      res_o.byte_count = total_n;
      res_o.kind       = kind_n;
      res_o.error      = over ? ebvd_pkg::ErrSizeMax : ebvd_pkg::ErrNone;
      busy_d  = 1'b0;
      tails_d = '0;
      total_d = '0;
      acc_d   = '0;
    end else begin
      busy_d  = 1'b1;
      tails_d = tails_n;
      total_d = total_n;
      acc_d   = acc_n;
    end
  end

  assign advance_o   = item_i.valid && (!emit || res_ready_i);
  assign res_valid_o = item_i.valid && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= ebvd_pkg::MaxSizeReset;
      busy_q     <= 1'b0;
      tails_q    <= '0;
      total_q    <= '0;
      acc_q      <= '0;
      mode_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_size_q <= cfg_wdata_i;
      end
      if (advance_o) begin
        busy_q  <= busy_d;
        tails_q <= tails_d;
        total_q <= total_d;
        acc_q   <= acc_d;
        mode_q  <= mode_d;
      end
    end
  end

  a_busy_has_tails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> tails_q != '0)
    else $error("busy with no tail bytes pending");

  a_id_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && mode_q == ebvd_pkg::ModeId) |-> total_q <= ebvd_pkg::CountWidth'(3))
    else $error("element ID collection beyond four bytes");

  a_long_id_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.error == ebvd_pkg::ErrIdLong) |->
      (res_o.kind == ebvd_pkg::ModeId && res_o.byte_count == ebvd_pkg::CountWidth'(1)))
    else $error("long ID result malformed");

  a_advance_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_o && res_valid_o) |=> !busy_q)
    else $error("still busy after a result transfer");

endmodule

/* hdl/ebvd_out_stage.sv */
module ebvd_out_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                res_valid_i,
  input  ebvd_pkg::ebvd_result_t              res_i,
  output logic                                res_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ebvd_pkg::ValueWidth-1:0]     value_o,
  output logic [ebvd_pkg::CountWidth-1:0]     byte_count_o,
  output logic                                kind_o,
  output logic [1:0]                          error_o
);

  logic                   valid_q;
  ebvd_pkg::ebvd_result_t res_q;
  logic                   load;

  assign res_ready_o = !valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign value_o      = res_q.value;
  assign byte_count_o = res_q.byte_count;
  assign kind_o       = res_q.kind;
  assign error_o      = res_q.error;

endmodule

/* hdl/ebml_vint_decoder_unit.sv */
// A final byte is held in the input register; its result is registered to raise out_valid_o.
// Throughput: one byte per cycle unless stalled; input and result registers decouple the sides.
// Each byte's decode (leading-zero encode, accumulate, size compare) is combinational.
// Reset: asynchronous, active low; clears state to idle, empties both registers,
// and loads max_size with 1000.
module ebml_vint_decoder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ebvd_pkg::ValueWidth-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            mode_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ebvd_pkg::ValueWidth-1:0] value_o,
  output logic [ebvd_pkg::CountWidth-1:0] byte_count_o,
  output logic                            kind_o,
  output logic [1:0]                      error_o
);

  ebvd_pkg::ebvd_item_t   item;
  ebvd_pkg::ebvd_result_t res;
  logic                   advance;
  logic                   res_valid;
  logic                   res_ready;

  ebvd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .mode_i      (mode_i),
    .advance_i   (advance),
    .item_o      (item)
  );

  ebvd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .res_ready_i (res_ready),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ebvd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .res_ready_o  (res_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .byte_count_o (byte_count_o),
    .kind_o       (kind_o),
    .error_o      (error_o)
  );

endmodule
